### src/i8dpr_pkg.sv
`default_nettype none
package i8dpr_pkg;

  // Lane count of the datapath and the default number of lanes in use.
  localparam int unsigned LANES_MAX = 4;
  localparam int unsigned LANES_DEF = 4;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned LANE_W  = 8;
  localparam int unsigned OPND_W  = 32;
  localparam int unsigned SHIFT_W = 7;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned RES_W   = 8;

  // Packed stream widths.
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 8;

  // Command codes as they arrive on the input tuser.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MAC    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  // Saturation bounds of the result.
  localparam logic [RES_W-1:0] SAT_POS = 8'd127;
  localparam logic [RES_W-1:0] SAT_NEG = 8'h81;
  localparam logic [PROD_W-1:0] SAT_MAG = 64'd127;

  // Operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MAC,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                             op;
    logic [LANES_MAX-1:0][LANE_W-1:0] act;
    logic [LANES_MAX-1:0][LANE_W-1:0] weight;
    logic [OPND_W-1:0]               operand;
    logic [SHIFT_W-1:0]              shift;
  } item_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

### src/i8dpr_queue.sv
`default_nettype none
module i8dpr_queue #(
  parameter int unsigned Depth = i8dpr_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire i8dpr_pkg::item_t   push_item,
  input  wire logic               pop,
  output i8dpr_pkg::item_t        head_item,
  output i8dpr_pkg::queue_stat_t  stat
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i8dpr_pkg::item_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (count_r == CntW'(Depth));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### src/i8dpr_front.sv
`default_nettype none
module i8dpr_front #(
  parameter int unsigned Lanes = i8dpr_pkg::LANES_DEF
) (
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [i8dpr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [i8dpr_pkg::CMD_W-1:0]      in_tuser,
  input  wire i8dpr_pkg::queue_stat_t           stat,
  output logic                                  push,
  output i8dpr_pkg::item_t                      push_item
);

  logic known_cmd;

  // Requests are taken whenever the queue has room.
  assign in_tready = !stat.full;

  // Classify the command and unpack the fields; the unused code is accepted
  // and dropped, and lanes beyond the configured count get a zero weight.
  always_comb begin
    known_cmd    = 1'b1;
    push_item.op = i8dpr_pkg::OP_LOAD;
    case (in_tuser)
      i8dpr_pkg::CMD_LOAD:   push_item.op = i8dpr_pkg::OP_LOAD;
      i8dpr_pkg::CMD_MAC:    push_item.op = i8dpr_pkg::OP_MAC;
      i8dpr_pkg::CMD_FINISH: push_item.op = i8dpr_pkg::OP_FINISH;
      default:               known_cmd    = 1'b0;
    endcase
    for (int i = 0; i < i8dpr_pkg::LANES_MAX; i++) begin
      push_item.act[i] = in_tdata[i*i8dpr_pkg::LANE_W +: i8dpr_pkg::LANE_W];
      if (i < Lanes) begin
        push_item.weight[i] =
          in_tdata[(i8dpr_pkg::LANES_MAX + i)*i8dpr_pkg::LANE_W +: i8dpr_pkg::LANE_W];
      end else begin
        push_item.weight[i] = '0;
      end
    end
    push_item.operand = in_tdata[64 +: i8dpr_pkg::OPND_W];
    push_item.shift   = in_tdata[96 +: i8dpr_pkg::SHIFT_W];
  end

  assign push = in_tvalid && in_tready && known_cmd;

endmodule
`default_nettype wire

### src/i8dpr_back.sv
`default_nettype none
module i8dpr_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire i8dpr_pkg::item_t                  head_item,
  input  wire i8dpr_pkg::queue_stat_t            stat,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [i8dpr_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [0:0]                             out_tuser
);

  localparam int unsigned PW = i8dpr_pkg::PROD_W;

  logic                          advance;
  logic [i8dpr_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [i8dpr_pkg::ACC_W-1:0]   lane_sum;
  logic signed [15:0]            lane_prod [i8dpr_pkg::LANES_MAX];
  logic signed [31:0]            mul_a, mul_b;
  logic signed [PW-1:0]          prod;

  // Stage 1: exact product.
  logic                          s1_valid_r;
  logic [PW-1:0]                 s1_prod_r;
  logic [i8dpr_pkg::SHIFT_W-1:0] s1_shift_r;

  // Stage 2: rounded magnitude or left-shifted value.
  logic                          s2_valid_r;
  logic [PW-1:0]                 s2_val_r, s2_val_nxt;
  logic                          s2_right_r, s2_right_nxt;
  logic                          s2_neg_r;
  logic [5:0]                    s2_shift_r;
  logic [i8dpr_pkg::SHIFT_W-1:0] left_amt;
  logic [PW-1:0]                 s1_mag;

  // Stage 3: saturation into the output register.
  logic                          out_valid_r;
  logic [i8dpr_pkg::RES_W-1:0]   res_r, res_nxt;
  logic                          clip_r, clip_nxt;
  logic [PW-1:0]                 mag3;
  logic                          neg3;

  // The whole back pipeline holds while a result waits at the output.
  assign advance = !out_valid_r || out_tready;
  assign pop     = advance && !stat.empty;

  // Four int8 lane products summed into the wrapping accumulator.
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < i8dpr_pkg::LANES_MAX; i++) begin
      lane_prod[i] = $signed(head_item.act[i]) * $signed(head_item.weight[i]);
      lane_sum     = lane_sum + {{16{lane_prod[i][15]}}, lane_prod[i]};
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (pop) begin
      case (head_item.op)
        i8dpr_pkg::OP_LOAD: acc_nxt = head_item.operand;
        i8dpr_pkg::OP_MAC:  acc_nxt = acc_r + lane_sum;
        default:            acc_nxt = acc_r;
      endcase
    end
  end

  // Signed 32 by 32 multiply of the accumulator by the multiplier.
  assign mul_a = $signed(acc_r);
  assign mul_b = $signed(head_item.operand);
  assign prod  = mul_a * mul_b;

  // Positive shifts round the magnitude; other shifts move left, zero at 64.
  always_comb begin
    s2_right_nxt = (s1_shift_r != '0) && !s1_shift_r[6];
    left_amt     = ~s1_shift_r + 1'b1;
    s1_mag       = s1_prod_r[PW-1] ? (~s1_prod_r + 1'b1) : s1_prod_r;
    if (s2_right_nxt) begin
      s2_val_nxt = s1_mag + (64'd1 << (s1_shift_r[5:0] - 6'd1));
    end else if (left_amt[6]) begin
      s2_val_nxt = '0;
    end else begin
      s2_val_nxt = s1_prod_r << left_amt[5:0];
    end
  end

  // Finish the shift, take the sign and clamp to -127..127.
  always_comb begin
    if (s2_right_r) begin
      neg3 = s2_neg_r;
      mag3 = s2_val_r >> s2_shift_r;
    end else begin
      neg3 = s2_val_r[PW-1];
      mag3 = neg3 ? (~s2_val_r + 1'b1) : s2_val_r;
    end
    clip_nxt = (mag3 > i8dpr_pkg::SAT_MAG);
    if (clip_nxt) begin
      res_nxt = neg3 ? i8dpr_pkg::SAT_NEG : i8dpr_pkg::SAT_POS;
    end else begin
      res_nxt = neg3 ? (~mag3[7:0] + 1'b1) : mag3[7:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      if (advance) begin
        s1_valid_r  <= pop && (head_item.op == i8dpr_pkg::OP_FINISH);
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod_r  <= prod;
      s1_shift_r <= head_item.shift;
      s2_val_r   <= s2_val_nxt;
      s2_right_r <= s2_right_nxt;
      s2_neg_r   <= s1_prod_r[PW-1];
      s2_shift_r <= s1_shift_r[5:0];
      res_r      <= res_nxt;
      clip_r     <= clip_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;
  assign out_tuser  = clip_r;

endmodule
`default_nettype wire

### src/int8_dot_product_requant_unit.sv
`default_nettype none
// Channel  Dir  Ports                            Content
// in       in   in_tvalid/in_tready/in_tdata     lanes, operand, shift; tuser = cmd
// out      out  out_tvalid/out_tready/out_tdata  result_value; tuser = clipped
//
// One request is taken per cycle while the queue has room; a finish request
// leaves the two-entry queue and runs through a three-stage back end (32x32
// multiply, round or shift, clamp) into the output register. Load and
// accumulate requests update the accumulator as they leave the queue and give
// no result.
// Reset (rst_n low, synchronous) clears the accumulator to zero and empties
// the queue and pipeline. A stalled output freezes the back end; the queue
// keeps taking requests until it is full.
module int8_dot_product_requant_unit #(
  parameter int unsigned Lanes = i8dpr_pkg::LANES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // act_0, act_1, act_2, act_3, weight_0..weight_3, operand_value,
  // shift_amount, one zero pad bit
  input  wire logic [i8dpr_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd
  input  wire logic [i8dpr_pkg::CMD_W-1:0]       in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // result_value
  output logic [i8dpr_pkg::OUT_DATA_W-1:0]       out_tdata,
  // clipped
  output logic [0:0]                             out_tuser
);

  i8dpr_pkg::item_t       push_item;
  i8dpr_pkg::item_t       head_item;
  i8dpr_pkg::queue_stat_t stat;
  logic                   push;
  logic                   pop;

  i8dpr_front #(
    .Lanes(Lanes)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  i8dpr_queue #(
    .Depth(i8dpr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (stat)
  );

  i8dpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
